// ===== rtl/tlig_pkg.sv =====
// terrain lod index generator: shared types, constants and operation codes
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package tlig_pkg;

  localparam int IDX_W   = 17;
  localparam int COORD_W = 9;
  localparam int SIDE_W  = 9;
  localparam int LOD_W   = 5;
  localparam int MAX_LOD = 16;

  // register indexes on the configuration port
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOD          = 2'd2;

  localparam logic [SIDE_W-1:0] RESET_SIDE = 9'd129;
  localparam logic [LOD_W-1:0]  RESET_LOD  = 5'd1;

  // triangle step codes; a fan step runs lod triangles, the others one
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_BAD       = 4'd0;
  localparam logic [OP_W-1:0] OP_FINE_LO   = 4'd1;
  localparam logic [OP_W-1:0] OP_FINE_HI   = 4'd2;
  localparam logic [OP_W-1:0] OP_QUAD_LO   = 4'd3;
  localparam logic [OP_W-1:0] OP_QUAD_HI   = 4'd4;
  localparam logic [OP_W-1:0] OP_FAN_LEFT  = 4'd5;
  localparam logic [OP_W-1:0] OP_FAN_LEFTC = 4'd6;
  localparam logic [OP_W-1:0] OP_FAN_TOP   = 4'd7;
  localparam logic [OP_W-1:0] OP_FAN_TOPC  = 4'd8;
  localparam logic [OP_W-1:0] OP_FAN_RIGHT = 4'd9;
  localparam logic [OP_W-1:0] OP_FAN_BOT   = 4'd10;
  localparam logic [OP_W-1:0] OP_FAN_BR1   = 4'd11;
  localparam logic [OP_W-1:0] OP_FAN_BR2   = 4'd12;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // one classified cell, ready for the triangle sequencer
  typedef struct packed {
    logic [OP_W-1:0]   op_first;
    logic [OP_W-1:0]   op_second;
    logic              one_step;
    logic [IDX_W-1:0]  b;
    logic [IDX_W-1:0]  bl;
    logic [IDX_W-1:0]  bd;
    logic [IDX_W-1:0]  bdl;
    logic [SIDE_W-1:0] wd;
    logic [LOD_W-1:0]  lod;
  } tlig_desc_t;

  function automatic logic op_is_fan(input logic [OP_W-1:0] op);
    logic r;
    r = (op == OP_FAN_LEFT) || (op == OP_FAN_LEFTC) || (op == OP_FAN_TOP) ||
        (op == OP_FAN_TOPC) || (op == OP_FAN_RIGHT) || (op == OP_FAN_BOT) ||
        (op == OP_FAN_BR1)  || (op == OP_FAN_BR2);
    return r;
  endfunction

endpackage

// ===== rtl/tlig_front.sv =====
// front end: accepts cell words, classifies the cell and computes base indices
// depends on tlig_pkg; feeds tlig_queue
`timescale 1ns / 1ps

module tlig_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tlig_pkg::COORD_W-1:0]  cell_x,
  input  logic [tlig_pkg::COORD_W-1:0]  cell_y,
  input  logic [tlig_pkg::SIDE_W-1:0]   wd,
  input  logic [tlig_pkg::SIDE_W-1:0]   hd,
  input  logic [tlig_pkg::LOD_W-1:0]    lod,
  input  logic                          q_full,
  output logic                          q_push,
  output tlig_pkg::tlig_desc_t          q_data
);

  localparam int PW = tlig_pkg::COORD_W + 1 + tlig_pkg::LOD_W;

  // stage one registers
  logic                          f1_valid;
  logic [tlig_pkg::OP_W-1:0]     f1_op_first;
  logic [tlig_pkg::OP_W-1:0]     f1_op_second;
  logic                          f1_one_step;
  logic [tlig_pkg::COORD_W-1:0]  f1_x;
  logic [tlig_pkg::IDX_W-1:0]    f1_yw;
  logic [tlig_pkg::SIDE_W-1:0]   f1_wd;
  logic [tlig_pkg::LOD_W-1:0]    f1_lod;

  // stage two registers
  logic                          f2_valid;
  logic [tlig_pkg::OP_W-1:0]     f2_op_first;
  logic [tlig_pkg::OP_W-1:0]     f2_op_second;
  logic                          f2_one_step;
  logic [tlig_pkg::IDX_W-1:0]    f2_b;
  logic [tlig_pkg::IDX_W-1:0]    f2_dn;
  logic [tlig_pkg::SIDE_W-1:0]   f2_wd;
  logic [tlig_pkg::LOD_W-1:0]    f2_lod;

  logic f1_move, f2_move, accept;

  logic [tlig_pkg::LOD_W-1:0] lod_sat;
  logic [PW-1:0] x1l, x2l, y1l, y2l;
  logic [tlig_pkg::COORD_W:0] xp1, xp2, yp1, yp2;
  logic in_x, in_y, last_x, last_y, x0, y0;
  logic [tlig_pkg::OP_W-1:0] op_first, op_second;
  logic one_step;

  assign f2_move  = f2_valid && !q_full;
  assign f1_move  = f1_valid && (!f2_valid || f2_move);
  assign in_ready = !f1_valid || f1_move;
  assign accept   = in_valid && in_ready;

  // classification, one small multiply per bound test
  always_comb begin
    if (lod == '0) begin
      lod_sat = tlig_pkg::LOD_W'(1);
    end else if (lod > tlig_pkg::LOD_W'(tlig_pkg::MAX_LOD)) begin
      lod_sat = tlig_pkg::LOD_W'(tlig_pkg::MAX_LOD);
    end else begin
      lod_sat = lod;
    end
    xp1 = {1'b0, cell_x} + (tlig_pkg::COORD_W+1)'(1);
    xp2 = {1'b0, cell_x} + (tlig_pkg::COORD_W+1)'(2);
    yp1 = {1'b0, cell_y} + (tlig_pkg::COORD_W+1)'(1);
    yp2 = {1'b0, cell_y} + (tlig_pkg::COORD_W+1)'(2);
    x1l = PW'(xp1) * PW'(lod_sat);
    x2l = PW'(xp2) * PW'(lod_sat);
    y1l = PW'(yp1) * PW'(lod_sat);
    y2l = PW'(yp2) * PW'(lod_sat);
    x0 = (cell_x == '0);
    y0 = (cell_y == '0);
    // fine grid has side-1 cells, coarse grid has floor(side/lod)
    if (lod_sat == tlig_pkg::LOD_W'(1)) begin
      in_x = PW'(xp2) <= PW'(wd);
      in_y = PW'(yp2) <= PW'(hd);
    end else begin
      in_x = x1l <= PW'(wd);
      in_y = y1l <= PW'(hd);
    end
    last_x = x2l > PW'(wd);
    last_y = y2l > PW'(hd);

    op_first  = tlig_pkg::OP_BAD;
    op_second = tlig_pkg::OP_BAD;
    one_step  = 1'b0;
    if (!(in_x && in_y)) begin
      one_step = 1'b1;
    end else if (lod_sat == tlig_pkg::LOD_W'(1)) begin
      op_first  = tlig_pkg::OP_FINE_LO;
      op_second = tlig_pkg::OP_FINE_HI;
    end else if (x0) begin
      if (y0) begin
        op_first  = tlig_pkg::OP_FAN_LEFTC;
        op_second = tlig_pkg::OP_FAN_TOPC;
      end else if (last_y) begin
        op_first  = tlig_pkg::OP_FAN_LEFT;
        op_second = tlig_pkg::OP_FAN_BOT;
      end else begin
        op_first  = tlig_pkg::OP_QUAD_HI;
        op_second = tlig_pkg::OP_FAN_LEFT;
      end
    end else if (y0) begin
      if (last_x) begin
        op_first  = tlig_pkg::OP_FAN_TOP;
        op_second = tlig_pkg::OP_FAN_RIGHT;
      end else begin
        op_first  = tlig_pkg::OP_QUAD_HI;
        op_second = tlig_pkg::OP_FAN_TOP;
      end
    end else if (last_x) begin
      if (last_y) begin
        op_first  = tlig_pkg::OP_FAN_BR1;
        op_second = tlig_pkg::OP_FAN_BR2;
      end else begin
        op_first  = tlig_pkg::OP_QUAD_LO;
        op_second = tlig_pkg::OP_FAN_RIGHT;
      end
    end else if (last_y) begin
      op_first  = tlig_pkg::OP_QUAD_LO;
      op_second = tlig_pkg::OP_FAN_BOT;
    end else begin
      op_first  = tlig_pkg::OP_QUAD_LO;
      op_second = tlig_pkg::OP_QUAD_HI;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        f1_valid <= in_valid;
      end
      if (!f2_valid || f2_move) begin
        f2_valid <= f1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_op_first  <= op_first;
      f1_op_second <= op_second;
      f1_one_step  <= one_step;
      f1_x         <= cell_x;
      f1_yw        <= tlig_pkg::IDX_W'(cell_y) * tlig_pkg::IDX_W'(wd);
      f1_wd        <= wd;
      f1_lod       <= lod_sat;
    end
    if (f1_move) begin
      f2_op_first  <= f1_op_first;
      f2_op_second <= f1_op_second;
      f2_one_step  <= f1_one_step;
      f2_b   <= (f1_yw + tlig_pkg::IDX_W'(f1_x)) * tlig_pkg::IDX_W'(f1_lod);
      f2_dn  <= tlig_pkg::IDX_W'(f1_wd) * tlig_pkg::IDX_W'(f1_lod);
      f2_wd  <= f1_wd;
      f2_lod <= f1_lod;
    end
  end

  assign q_push = f2_move;

  always_comb begin
    q_data.op_first  = f2_op_first;
    q_data.op_second = f2_op_second;
    q_data.one_step  = f2_one_step;
    q_data.b         = f2_b;
    q_data.bl        = f2_b + tlig_pkg::IDX_W'(f2_lod);
    q_data.bd        = f2_b + f2_dn;
    q_data.bdl       = f2_b + f2_dn + tlig_pkg::IDX_W'(f2_lod);
    q_data.wd        = f2_wd;
    q_data.lod       = f2_lod;
  end

endmodule

// ===== rtl/tlig_queue.sv =====
// short descriptor queue between the front end and the triangle sequencer
// depends on tlig_pkg
`timescale 1ns / 1ps

module tlig_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  tlig_pkg::tlig_desc_t  push_data,
  output logic                  full,
  input  logic                  pop,
  output logic                  head_valid,
  output tlig_pkg::tlig_desc_t  head
);

  tlig_pkg::tlig_desc_t entries [tlig_pkg::QUEUE_DEPTH];
  logic [tlig_pkg::QPTR_W-1:0] wr_ptr;
  logic [tlig_pkg::QPTR_W-1:0] rd_ptr;
  logic [tlig_pkg::QPTR_W:0]   count;

  assign full       = (count == (tlig_pkg::QPTR_W+1)'(tlig_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + tlig_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + tlig_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (tlig_pkg::QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (tlig_pkg::QPTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== rtl/tlig_back.sv =====
// back end: steps through a cell's triangles, one per cycle, into the output register
// unless out_ready stalls it; depends on tlig_pkg; reads descriptors from tlig_queue
`timescale 1ns / 1ps

module tlig_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        head_valid,
  input  tlig_pkg::tlig_desc_t        head,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tlig_pkg::IDX_W-1:0]  index_first,
  output logic [tlig_pkg::IDX_W-1:0]  index_second,
  output logic [tlig_pkg::IDX_W-1:0]  index_third,
  output logic                        last_triangle,
  output logic                        bad_cell
);

  logic                       phase;
  logic [tlig_pkg::LOD_W-1:0] v;
  logic [tlig_pkg::IDX_W-1:0] wv;

  logic [tlig_pkg::OP_W-1:0]  op;
  logic [tlig_pkg::IDX_W-1:0] wv1, vv, bv, bwv, bwv1, blwv, blwv1, bdv;
  logic [tlig_pkg::IDX_W-1:0] t0, t1, t2;
  logic adv, fan, step_end, item_end;

  assign adv = head_valid && (!out_valid || out_ready);
  assign op  = phase ? head.op_second : head.op_first;

  always_comb begin
    wv1   = wv + tlig_pkg::IDX_W'(head.wd);
    vv    = tlig_pkg::IDX_W'(v);
    bv    = head.b + vv;
    bwv   = head.b + wv;
    bwv1  = head.b + wv1;
    blwv  = head.bl + wv;
    blwv1 = head.bl + wv1;
    bdv   = head.bd + vv;
    t0 = '0;
    t1 = '0;
    t2 = '0;
    case (op)
      tlig_pkg::OP_BAD: begin
        t0 = '0; t1 = '0; t2 = '0;
      end
      tlig_pkg::OP_FINE_LO: begin
        t0 = head.b; t1 = bwv1; t2 = head.b + tlig_pkg::IDX_W'(1);
      end
      tlig_pkg::OP_FINE_HI: begin
        t0 = head.b + tlig_pkg::IDX_W'(1); t1 = bwv1;
        t2 = bwv1 + tlig_pkg::IDX_W'(1);
      end
      tlig_pkg::OP_QUAD_LO: begin
        t0 = head.b; t1 = head.bd; t2 = head.bl;
      end
      tlig_pkg::OP_QUAD_HI: begin
        t0 = head.bl; t1 = head.bd; t2 = head.bdl;
      end
      tlig_pkg::OP_FAN_LEFT: begin
        t0 = bwv; t1 = bwv1; t2 = head.bl;
      end
      tlig_pkg::OP_FAN_LEFTC: begin
        t0 = bwv; t1 = bwv1; t2 = head.bdl;
      end
      tlig_pkg::OP_FAN_TOP: begin
        t0 = bv; t1 = head.bd; t2 = bv + tlig_pkg::IDX_W'(1);
      end
      tlig_pkg::OP_FAN_TOPC: begin
        t0 = bv; t1 = head.bdl; t2 = bv + tlig_pkg::IDX_W'(1);
      end
      tlig_pkg::OP_FAN_RIGHT: begin
        t0 = blwv; t1 = head.bd; t2 = blwv1;
      end
      tlig_pkg::OP_FAN_BOT: begin
        t0 = head.bl; t1 = bdv; t2 = bdv + tlig_pkg::IDX_W'(1);
      end
      tlig_pkg::OP_FAN_BR1: begin
        t0 = head.b; t1 = bdv; t2 = bdv + tlig_pkg::IDX_W'(1);
      end
      tlig_pkg::OP_FAN_BR2: begin
        t0 = head.b; t1 = blwv1; t2 = blwv;
      end
      default: begin
        t0 = '0; t1 = '0; t2 = '0;
      end
    endcase
    fan      = tlig_pkg::op_is_fan(op);
    step_end = !fan || (v == head.lod - tlig_pkg::LOD_W'(1));
    item_end = step_end && (phase || head.one_step);
  end

  assign pop = adv && item_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
      v         <= '0;
      wv        <= '0;
    end else begin
      if (adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (adv) begin
        if (step_end) begin
          phase <= !item_end;
          v     <= '0;
          wv    <= '0;
        end else begin
          v  <= v + tlig_pkg::LOD_W'(1);
          wv <= wv1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      index_first   <= t0;
      index_second  <= t1;
      index_third   <= t2;
      last_triangle <= item_end;
      bad_cell      <= (op == tlig_pkg::OP_BAD);
    end
  end

endmodule

// ===== rtl/terrain_lod_index_generator.sv =====
// top level of the terrain lod index generator: configuration registers and wiring
// depends on tlig_pkg, tlig_front, tlig_queue and tlig_back
`timescale 1ns / 1ps

// Takes one coarse cell coordinate (cell_x, cell_y) of a row-major vertex block
// and returns the cell's triangles as vertex index triples, one triangle per output
// word, with last_triangle set on the final one. At level of detail 1 each cell
// gives two triangles; above that, interior cells give two, edge cells 1+lod and
// corner cells 2*lod, fanned to stitch against full-resolution neighbors. A cell
// outside the coarse grid gives a single word with bad_cell and last_triangle set
// and zero indices. Indices wrap to 17 bits. A level of 0 acts as 1 and levels
// above 16 act as 16. The output side produces one triangle per clock unless
// out_ready stalls it, and that output sequencer sets the pace. A cell word
// goes through two front stages (classify, then base index multiply) and a
// 4-deep descriptor queue, so the front keeps taking words while the back is
// busy fanning. Configuration must only be written while the block is idle;
// the block itself does not enforce this. Writes to index 3 are ignored.

module terrain_lod_index_generator (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration write port
  input  logic                                 cfg_write,
  input  logic [tlig_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tlig_pkg::SIDE_W-1:0]          cfg_data,
  // cell word in
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [tlig_pkg::COORD_W-1:0]         cell_x,
  input  logic [tlig_pkg::COORD_W-1:0]         cell_y,
  // triangle word out
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [tlig_pkg::IDX_W-1:0]           index_first,
  output logic [tlig_pkg::IDX_W-1:0]           index_second,
  output logic [tlig_pkg::IDX_W-1:0]           index_third,
  output logic                                 last_triangle,
  output logic                                 bad_cell
);

  // configuration registers
  logic [tlig_pkg::SIDE_W-1:0] block_width;
  logic [tlig_pkg::SIDE_W-1:0] block_height;
  logic [tlig_pkg::LOD_W-1:0]  level_of_detail;

  // front to queue
  logic                  q_push;
  logic                  q_full;
  tlig_pkg::tlig_desc_t  q_data;

  // queue to back
  logic                  q_pop;
  logic                  q_valid;
  tlig_pkg::tlig_desc_t  q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_width     <= tlig_pkg::RESET_SIDE;
      block_height    <= tlig_pkg::RESET_SIDE;
      level_of_detail <= tlig_pkg::RESET_LOD;
    end else if (cfg_write) begin
      case (cfg_index)
        tlig_pkg::CFG_BLOCK_WIDTH:  block_width     <= cfg_data;
        tlig_pkg::CFG_BLOCK_HEIGHT: block_height    <= cfg_data;
        tlig_pkg::CFG_LOD:          level_of_detail <= cfg_data[tlig_pkg::LOD_W-1:0];
        default: begin
          // unmapped index, nothing to write
        end
      endcase
    end
  end

  // front end: handshake, bound tests, case selection, base indices
  tlig_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cell_x   (cell_x),
    .cell_y   (cell_y),
    .wd       (block_width),
    .hd       (block_height),
    .lod      (level_of_detail),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_data)
  );

  // decouples the classifier from the triangle sequencer
  tlig_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  // back end: one triangle per cycle into the output register while out_ready allows
  tlig_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (q_valid),
    .head          (q_head),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .index_first   (index_first),
    .index_second  (index_second),
    .index_third   (index_third),
    .last_triangle (last_triangle),
    .bad_cell      (bad_cell)
  );

  // a bad cell word is always a lone, final, all-zero word
  a_bad_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_cell |-> last_triangle && index_first == '0 &&
                              index_second == '0 && index_third == '0)
    else $error("bad cell word not final or not zero");

  // the sequencer only retires a descriptor the queue holds
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("descriptor retired from empty queue");

  // the front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full || q_pop)
    else $error("descriptor queue overflow");

  // a queued level of detail is already saturated into 1..16
  a_lod_range: assert property (@(posedge clk) disable iff (rst)
    q_valid |-> q_head.lod != '0 &&
                q_head.lod <= tlig_pkg::LOD_W'(tlig_pkg::MAX_LOD))
    else $error("queued level of detail out of range");

endmodule
